// File: rtl/bsd_pkg.sv
// bsd_pkg: shared types and constants for the bounded stack with dump unit
// no dependencies; imported by the controller, datapath and top level

package bsd_pkg;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CAP_W   = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP_TB = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP_BT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// controller to datapath
	typedef struct packed {
		logic push;
		logic pop;
		logic start;
		logic start_down;
		logic start_peek;
		logic rd_go;
	} bsd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic room;
		logic left_one;
	} bsd_sts_t;

endpackage

// File: rtl/bsd_ram.sv
// bsd_ram: generic single-write, single-read ram with registered read data
// no dependencies

module bsd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bsd_ctrl.sv
// bsd_ctrl: command decode and run sequencing for the stack unit
// depends on bsd_pkg

module bsd_ctrl import bsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [CMD_W-1:0] s_tuser,
	input  bsd_sts_t         sts,
	output bsd_cmd_t         cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						CMD_PUSH: cmd.push = ~sts.full;
						CMD_POP:  cmd.pop  = ~sts.empty;
						CMD_DUMP_TB: begin
							cmd.start      = ~sts.empty;
							cmd.start_down = 1'b1;
						end
						CMD_DUMP_BT: cmd.start = ~sts.empty;
						CMD_PEEK: begin
							cmd.start      = ~sts.empty;
							cmd.start_down = 1'b1;
							cmd.start_peek = 1'b1;
						end
						default: ;
					endcase
					if (cmd.start) begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.rd_go = sts.room;
				if (sts.room && sts.left_one) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/bsd_dp.sv
// bsd_dp: stack storage, entry count, read pointer and two-word output buffer
// depends on bsd_pkg and bsd_ram

module bsd_dp import bsd_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bsd_cmd_t                  cmd,
	output bsd_sts_t                  sts,
	input  logic signed [VALUE_W-1:0] push_value,
	input  logic                      cfg_wen,
	input  logic [CAP_W-1:0]          cfg_wdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic signed [VALUE_W-1:0] m_tdata,
	output logic                      m_tlast
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);

	logic [CAP_W-1:0]   cap_q;
	logic [CAP_W-1:0]   limit;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      ptr_q;
	logic [CW-1:0]      left_q;
	logic               down_q;
	logic               infl_q;
	logic               infl_last_q;
	logic               skid_v_q;
	logic [VALUE_W-1:0] skid_data_q;
	logic               skid_last_q;
	logic               out_v_q;
	logic [VALUE_W-1:0] out_data_q;
	logic               out_last_q;
	logic [VALUE_W-1:0] rd_data;
	logic [1:0]         occ;
	logic               drain;
	logic               out_free;

	assign limit = (cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q;

	assign drain    = out_v_q & m_tready;
	assign out_free = drain | ~out_v_q;
	assign occ      = 2'(out_v_q) + 2'(skid_v_q) + 2'(infl_q);

	assign sts.empty    = (count_q == '0);
	assign sts.full     = (CAP_W'(count_q) >= limit);
	assign sts.room     = (occ < 2'd2) | ((occ == 2'd2) & drain);
	assign sts.left_one = (left_q == CW'(1));

	bsd_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (count_q[AW-1:0]),
		.wdata (push_value),
		.re    (cmd.rd_go),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	// configuration and stack bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// run pointer: walks down from the top or up from the base
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			down_q <= cmd.start_down;
			ptr_q  <= cmd.start_down ? AW'(count_q - CW'(1)) : '0;
			left_q <= cmd.start_peek ? CW'(1) : count_q;
		end else if (cmd.rd_go) begin
			ptr_q  <= down_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
			left_q <= left_q - CW'(1);
		end
	end

	// read in flight, skid word and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q   <= 1'b0;
			skid_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			infl_q <= cmd.rd_go;
			if (out_free) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= infl_q;
				end else begin
					out_v_q <= infl_q;
				end
			end else if (infl_q) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_go) begin
			infl_last_q <= sts.left_one;
		end
		if (out_free) begin
			if (skid_v_q) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
				if (infl_q) begin
					skid_data_q <= rd_data;
					skid_last_q <= infl_last_q;
				end
			end else if (infl_q) begin
				out_data_q <= rd_data;
				out_last_q <= infl_last_q;
			end
		end else if (infl_q) begin
			skid_data_q <= rd_data;
			skid_last_q <= infl_last_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/bounded_stack_with_dump_unit.sv
// bounded_stack_with_dump_unit: top level joining bsd_ctrl and bsd_dp, uses bsd_pkg
// push and pop finish when taken; a peek holds the input for its one ram read and a dump
// for one ram read per stored entry, longer while the output stalls
// a peek or dump's first result word passes the run state, ram read and output register
// arst_n clears the entry count, the run state and the output buffer and sets capacity
// to 64; stack contents are not cleared, only entries written by a push are ever read

module bounded_stack_with_dump_unit import bsd_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input word
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic signed [VALUE_W-1:0] s_tdata,   // [31:0] push_value
	input  logic [CMD_W-1:0]          s_tuser,   // [2:0] cmd
	// result word
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic signed [VALUE_W-1:0] m_tdata,   // [31:0] out_value
	output logic                      m_tlast,   // out_last
	// capacity register
	input  logic                      cfg_wen,
	input  logic [CAP_W-1:0]          cfg_wdata
);

	// command and status between the sequencer and the datapath
	bsd_cmd_t cmd;
	bsd_sts_t sts;

	// sequencer: decodes the command word and steps a dump or peek run
	bsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: ram, entry count, capacity limit, read pointer and output buffer
	bsd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.push_value (s_tdata),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// File: tb/stack_dump_checker.sv
`timescale 1ns / 1ps
// stack_dump_checker: watches the command, result and capacity channels of the stack unit
// keeps its own copy of the stack, predicts every result word and compares; uses bsd_pkg

module stack_dump_checker import bsd_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic signed [VALUE_W-1:0] s_tdata,
	input  logic [CMD_W-1:0]          s_tuser,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic signed [VALUE_W-1:0] m_tdata,
	input  logic                      m_tlast,
	input  logic                      cfg_wen,
	input  logic [CAP_W-1:0]          cfg_wdata,
	output int                        mismatches,
	output int                        pending,
	output int                        checked
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} result_word_t;

	logic signed [VALUE_W-1:0] stack_mem [DEPTH];
	int                        fill = 0;
	logic [CAP_W-1:0]          cap_reg = CAP_RESET;
	result_word_t              expected_words [$];

	initial begin
		mismatches = 0;
		pending = 0;
		checked = 0;
	end

	function automatic void apply_command(input logic [CMD_W-1:0] cmd,
			input logic signed [VALUE_W-1:0] data);
		int lim;
		int i;
		lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
		case (cmd)
			CMD_PUSH: begin
				if (fill < lim) begin
					stack_mem[fill] = data;
					fill++;
				end
			end
			CMD_POP: begin
				if (fill > 0)
					fill--;
			end
			CMD_DUMP_TB: begin
				for (i = fill; i > 0; i--)
					expected_words.push_back('{stack_mem[i-1], i == 1});
			end
			CMD_DUMP_BT: begin
				for (i = 0; i < fill; i++)
					expected_words.push_back('{stack_mem[i], i + 1 == fill});
			end
			CMD_PEEK: begin
				if (fill > 0)
					expected_words.push_back('{stack_mem[fill-1], 1'b1});
			end
			default: ;
		endcase
	endfunction

	function automatic void check_word(input logic signed [VALUE_W-1:0] value,
			input logic last);
		result_word_t want;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word: value %0d last %b", value, last);
			return;
		end
		want = expected_words.pop_front();
		checked++;
		if (value !== want.value || last !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result word %0d: expected value %0d last %b, got value %0d last %b",
					checked, want.value, want.last, value, last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			cap_reg = CAP_RESET;
			expected_words.delete();
			pending = 0;
		end else begin
			// older words first, a word taken now cannot answer a command taken now
			if (m_tvalid && m_tready)
				check_word(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata);
			if (cfg_wen)
				cap_reg = cfg_wdata;
			pending = expected_words.size();
		end
	end

endmodule

// File: tb/tb_bounded_stack_with_dump_unit.sv
`timescale 1ns / 1ps
// tb_bounded_stack_with_dump_unit: stimulus, back-pressure and verdict for the stack unit
// depends on bsd_pkg, bounded_stack_with_dump_unit and stack_dump_checker

module tb_bounded_stack_with_dump_unit;
	import bsd_pkg::*;

	// command codes the unit must ignore
	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam int SETTLE_CYCLES = 8;     // read, output register and two-word buffer
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int WATCHDOG      = 4000;  // cycles without any handshake
	localparam int NPHASE        = 10;
	localparam int HOLD_PHASE    = 7;

	// capacity, length and push share of each random phase
	localparam int PHASE_CAP  [NPHASE] = '{64, 1, 0, 127, 3, 100, 2, 64, 17, 64};
	localparam int PHASE_LEN  [NPHASE] = '{40, 30, 20, 55, 40, 40, 30, 50, 40, 40};
	localparam int PHASE_PUSH [NPHASE] = '{55, 50, 60, 90, 35, 60, 45, 40, 50, 50};

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic signed [VALUE_W-1:0] s_tdata;   // [31:0] push_value
	logic [CMD_W-1:0]          s_tuser;   // [2:0] cmd
	logic                      m_tvalid;
	logic                      m_tready;
	logic signed [VALUE_W-1:0] m_tdata;   // [31:0] out_value
	logic                      m_tlast;   // out_last
	logic                      cfg_wen;
	logic [CAP_W-1:0]          cfg_wdata;

	int mismatches;
	int pending;
	int checked;
	int items_sent = 0;
	int settings_written = 0;

	// steering between stimulus and receiver
	bit calm = 1'b0;      // last part of the run, no idling on either side
	bit hold_req = 1'b0;  // asks the receiver for its long hold-off

	wire s_fire = s_tvalid & s_tready;
	wire m_fire = m_tvalid & m_tready;

	bounded_stack_with_dump_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	stack_dump_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stall bursts, one long hold-off on request, none once calm
	initial begin
		int stall;
		bit hold_done;
		stall = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				// counted here, while the sender keeps offering words
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 16) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: ends the run when no word moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if (!arst_n || s_fire || m_fire)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d result words outstanding",
			WATCHDOG, pending);
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly random values, with the extremes mixed in
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
		int r;
		if ($urandom_range(0, 99) < push_pct)
			return CMD_PUSH;
		r = $urandom_range(0, 99);
		if (r < 35) return CMD_POP;
		if (r < 55) return CMD_PEEK;
		if (r < 70) return CMD_DUMP_TB;
		if (r < 85) return CMD_DUMP_BT;
		if (r < 90) return CMD_RSVD5;
		if (r < 95) return CMD_RSVD6;
		return CMD_RSVD7;
	endfunction

	// offer one command word, maybe after an idle burst, and wait for it to be taken
	task automatic offer_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] data);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// stop sending, wait for every predicted word, then let the pipeline empty
	task automatic drain_and_settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// capacity changes only while the unit is idle
	task automatic write_capacity(input int cap);
		drain_and_settle();
		cfg_wdata <= CAP_W'(cap);
		cfg_wen   <= 1'b1;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		settings_written++;
	endtask

	initial begin
		int p;
		int k;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_PUSH;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty stack at the reset capacity
		offer_word(CMD_PEEK, 32'h0000_0000);
		offer_word(CMD_DUMP_TB, 32'hffff_ffff);
		offer_word(CMD_DUMP_BT, 32'h0000_0000);
		offer_word(CMD_POP, 32'hffff_ffff);
		// unknown commands must leave the stack alone
		offer_word(CMD_RSVD5, 32'hffff_ffff);
		offer_word(CMD_RSVD6, 32'h0000_0000);
		offer_word(CMD_RSVD7, 32'hffff_ffff);
		// value extremes
		offer_word(CMD_PUSH, 32'h8000_0000);
		offer_word(CMD_PUSH, 32'h7fff_ffff);
		offer_word(CMD_PUSH, 32'h0000_0000);
		offer_word(CMD_PUSH, 32'hffff_ffff);
		offer_word(CMD_PEEK, 32'h0000_0000);
		offer_word(CMD_DUMP_TB, 32'h0000_0000);
		offer_word(CMD_DUMP_BT, 32'hffff_ffff);
		offer_word(CMD_POP, 32'h0000_0000);
		offer_word(CMD_PEEK, 32'hffff_ffff);

		// capacity lowered below the fill: entries stay, pushes refused
		write_capacity(2);
		offer_word(CMD_PUSH, 32'h1357_9bdf);
		offer_word(CMD_DUMP_BT, 32'h0000_0000);
		offer_word(CMD_POP, 32'h0000_0000);
		offer_word(CMD_POP, 32'h0000_0000);
		offer_word(CMD_PUSH, 32'h1234_5678);
		offer_word(CMD_PUSH, 32'hdead_beef);  // full at two, refused
		offer_word(CMD_DUMP_TB, 32'h0000_0000);

		// zero capacity refuses every push
		write_capacity(0);
		offer_word(CMD_PUSH, 32'h0bad_cafe);
		offer_word(CMD_PEEK, 32'h0000_0000);

		// random phases over several capacity settings
		for (p = 0; p < NPHASE; p++) begin
			write_capacity(PHASE_CAP[p]);
			if (p == NPHASE - 1)
				calm = 1'b1;
			if (p == HOLD_PHASE) begin
				// make sure dumps have entries, then choke the output
				repeat (8) offer_word(CMD_PUSH, pick_value());
				hold_req = 1'b1;
				offer_word(CMD_DUMP_TB, $urandom);
				offer_word(CMD_DUMP_BT, $urandom);
			end
			for (k = 0; k < PHASE_LEN[p]; k++)
				offer_word(pick_cmd(PHASE_PUSH[p]), pick_value());
		end

		drain_and_settle();
		repeat (20) @(negedge clk);

		$display("covered %0d command words over %0d capacity settings, zero, one, depth and saturated",
			items_sent, settings_written);
		$display("%0d result words compared with the predicted stack contents", checked);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/bsd_pkg.sv
rtl/bsd_ram.sv
rtl/bsd_ctrl.sv
rtl/bsd_dp.sv
rtl/bounded_stack_with_dump_unit.sv
tb/stack_dump_checker.sv
tb/tb_bounded_stack_with_dump_unit.sv
